// ===== design/i2cmw_pkg.sv =====
package i2cmw_pkg;

  localparam int unsigned AddrW  = 8;
  localparam int unsigned DelayW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned BitPosW = 4;
  localparam int unsigned ByteW  = 8;

  localparam logic [AddrW-1:0]  DevAddrRst = 8'd120;
  localparam logic [DelayW-1:0] DelayRst   = 16'd30;
  localparam logic [BitPosW-1:0] BitsPerByte = 4'd8;

  // register indexes
  localparam logic CfgDevAddr = 1'b0;
  localparam logic CfgDelay   = 1'b1;

  // slave tdata layout, from the lowest bit up
  localparam int unsigned InTdataW   = 16;
  localparam int unsigned InSenseBit = 0;
  localparam int unsigned InOfferBit = 1;
  localparam int unsigned InValueLsb = 2;

  // master tdata layout, from the lowest bit up
  localparam int unsigned OutTdataW  = 8;
  localparam int unsigned OutSclBit  = 0;
  localparam int unsigned OutSdaBit  = 1;
  localparam int unsigned OutTakeBit = 2;
  localparam int unsigned OutDoneBit = 3;
  localparam int unsigned OutNackBit = 4;
  localparam int unsigned OutBusyBit = 5;

  typedef enum logic [10:0] {
    PH_IDLE       = 11'b000_0000_0001,
    PH_START_HIGH = 11'b000_0000_0010,
    PH_START_LOW  = 11'b000_0000_0100,
    PH_BIT_SET    = 11'b000_0000_1000,
    PH_BIT_HIGH   = 11'b000_0001_0000,
    PH_ACK_REL    = 11'b000_0010_0000,
    PH_ACK_HIGH   = 11'b000_0100_0000,
    PH_HOLD       = 11'b000_1000_0000,
    PH_STOP_LOW   = 11'b001_0000_0000,
    PH_STOP_RISE  = 11'b010_0000_0000,
    PH_STOP_REL   = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [ByteW-1:0]    shift_byte;
    logic [ByteW-1:0]    held_ctrl;
    logic [BitPosW-1:0]  bit_pos;
    logic [DelayW-1:0]   wait_cnt;
    logic                stop_pending;
    logic                nack_latched;
    logic                addr_in_flight;
    logic                scl;
    logic                sda;
  } eng_state_t;

  typedef struct packed {
    logic             sda_sense;
    logic             byte_offered;
    logic [ByteW-1:0] byte_value;
    logic             byte_starts;
    logic             byte_ends;
  } in_word_t;

  typedef struct packed {
    logic scl_drive;
    logic sda_drive;
    logic byte_taken;
    logic transfer_done;
    logic transfer_nack;
    logic engine_busy;
  } out_word_t;

  localparam eng_state_t StateRst = '{
    phase:          PH_IDLE,
    shift_byte:     '0,
    held_ctrl:      '0,
    bit_pos:        '0,
    wait_cnt:       '0,
    stop_pending:   1'b0,
    nack_latched:   1'b0,
    addr_in_flight: 1'b0,
    scl:            1'b1,
    sda:            1'b1
  };

endpackage

// ===== design/i2cmw_step.sv =====
module i2cmw_step import i2cmw_pkg::*; (
  input  eng_state_t        state_i,
  input  in_word_t          word_i,
  input  logic [AddrW-1:0]  dev_addr_i,
  input  logic [DelayW-1:0] delay_i,
  output eng_state_t        state_o,
  output out_word_t         res_o
);

  eng_state_t           nx;
  logic                 taken;
  logic                 done;
  logic                 nack;
  logic [BitPosW-1:0]   pos_inc;

  assign pos_inc = state_i.bit_pos + 1'b1;

  always_comb begin
    nx    = state_i;
    taken = 1'b0;
    done  = 1'b0;
    nack  = 1'b0;
    if (state_i.wait_cnt != '0) begin
      nx.wait_cnt = state_i.wait_cnt - 1'b1;
    end else begin
      unique case (state_i.phase)
        PH_IDLE: begin
          if (word_i.byte_offered && word_i.byte_starts) begin
            taken             = 1'b1;
            nx.held_ctrl      = word_i.byte_value;
            nx.shift_byte     = dev_addr_i;
            nx.stop_pending   = word_i.byte_ends;
            nx.nack_latched   = 1'b0;
            nx.addr_in_flight = 1'b1;
            nx.bit_pos        = '0;
            nx.scl            = 1'b1;
            nx.sda            = 1'b1;
            nx.phase          = PH_START_HIGH;
            nx.wait_cnt       = delay_i;
          end
        end
        PH_START_HIGH: begin
          nx.sda      = 1'b0;
          nx.phase    = PH_START_LOW;
          nx.wait_cnt = delay_i;
        end
        PH_START_LOW: begin
          nx.scl        = 1'b0;
          nx.sda        = state_i.shift_byte[ByteW-1];
          nx.shift_byte = {state_i.shift_byte[ByteW-2:0], 1'b0};
          nx.phase      = PH_BIT_SET;
          nx.wait_cnt   = delay_i;
        end
        PH_BIT_SET: begin
          nx.scl      = 1'b1;
          nx.phase    = PH_BIT_HIGH;
          nx.wait_cnt = delay_i;
        end
        PH_BIT_HIGH: begin
          nx.bit_pos  = pos_inc;
          nx.scl      = 1'b0;
          nx.wait_cnt = delay_i;
          if (pos_inc >= BitsPerByte) begin
            nx.sda   = 1'b1;
            nx.phase = PH_ACK_REL;
          end else begin
            nx.sda        = state_i.shift_byte[ByteW-1];
            nx.shift_byte = {state_i.shift_byte[ByteW-2:0], 1'b0};
            nx.phase      = PH_BIT_SET;
          end
        end
        PH_ACK_REL: begin
          nx.scl      = 1'b1;
          nx.phase    = PH_ACK_HIGH;
          nx.wait_cnt = delay_i;
        end
        PH_ACK_HIGH: begin
          if (word_i.sda_sense || (!state_i.addr_in_flight && state_i.stop_pending)) begin
            // nack aborts, or acked final byte: go to stop
            if (word_i.sda_sense) begin
              nx.nack_latched = 1'b1;
            end
            nx.addr_in_flight = 1'b0;
            nx.scl            = 1'b0;
            nx.sda            = 1'b0;
            nx.phase          = PH_STOP_LOW;
            nx.wait_cnt       = delay_i;
          end else if (state_i.addr_in_flight) begin
            nx.addr_in_flight = 1'b0;
            nx.bit_pos        = '0;
            nx.scl            = 1'b0;
            nx.sda            = state_i.held_ctrl[ByteW-1];
            nx.shift_byte     = {state_i.held_ctrl[ByteW-2:0], 1'b0};
            nx.phase          = PH_BIT_SET;
            nx.wait_cnt       = delay_i;
          end else begin
            nx.scl   = 1'b0;
            nx.sda   = 1'b1;
            nx.phase = PH_HOLD;
          end
        end
        PH_HOLD: begin
          if (word_i.byte_offered) begin
            taken           = 1'b1;
            nx.stop_pending = word_i.byte_ends;
            nx.bit_pos      = '0;
            nx.wait_cnt     = delay_i;
            if (word_i.byte_starts) begin
              // repeated start
              nx.held_ctrl      = word_i.byte_value;
              nx.shift_byte     = dev_addr_i;
              nx.nack_latched   = 1'b0;
              nx.addr_in_flight = 1'b1;
              nx.scl            = 1'b1;
              nx.sda            = 1'b1;
              nx.phase          = PH_START_HIGH;
            end else begin
              nx.scl        = 1'b0;
              nx.sda        = word_i.byte_value[ByteW-1];
              nx.shift_byte = {word_i.byte_value[ByteW-2:0], 1'b0};
              nx.phase      = PH_BIT_SET;
            end
          end
        end
        PH_STOP_LOW: begin
          nx.scl      = 1'b1;
          nx.phase    = PH_STOP_RISE;
          nx.wait_cnt = delay_i;
        end
        PH_STOP_RISE: begin
          nx.sda      = 1'b1;
          nx.phase    = PH_STOP_REL;
          nx.wait_cnt = delay_i;
        end
        PH_STOP_REL: begin
          nack            = state_i.nack_latched;
          done            = !state_i.nack_latched;
          nx.stop_pending = 1'b0;
          nx.phase        = PH_IDLE;
        end
        default: begin
          nx.scl            = 1'b1;
          nx.sda            = 1'b1;
          nx.stop_pending   = 1'b0;
          nx.addr_in_flight = 1'b0;
          nx.phase          = PH_IDLE;
        end
      endcase
    end
  end

  assign state_o = nx;

  assign res_o = '{
    scl_drive:     nx.scl,
    sda_drive:     nx.sda,
    byte_taken:    taken,
    transfer_done: done,
    transfer_nack: nack,
    engine_busy:   (nx.phase != PH_IDLE)
  };

endmodule

// ===== design/i2c_master_write_engine_top.sv =====
// an accepted input word is held in the input register; its result word is then registered in
//   the result register and shows on the master side
// throughput: one word per cycle; the input stage advances when the result stage is empty
//   or draining, so a stalled result stops intake once the input stage is full
// reset (rst_ni low, asynchronous): both stages empty, engine idle with scl and sda
//   released, device_address 120, delay_ticks 30
module i2c_master_write_engine_top import i2cmw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sda_sense, byte_offered, byte_value[7:0], zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // byte_starts
  input  logic                 s_axis_tuser,
  // byte_ends
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // scl_drive, sda_drive, byte_taken, transfer_done, transfer_nack, engine_busy, zero pad
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  logic              in_vld_q;
  in_word_t          in_q;
  logic              out_vld_q;
  out_word_t         out_q;
  out_word_t         res;
  eng_state_t        st_q;
  eng_state_t        st_d;
  logic [AddrW-1:0]  dev_addr_q;
  logic [DelayW-1:0] delay_q;
  logic              advance;
  logic              in_fire;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrRst;
      delay_q    <= DelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDevAddr: dev_addr_q <= cfg_data_i[AddrW-1:0];
        CfgDelay:   delay_q    <= cfg_data_i[DelayW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= '{
        sda_sense:    s_axis_tdata[InSenseBit],
        byte_offered: s_axis_tdata[InOfferBit],
        byte_value:   s_axis_tdata[InValueLsb +: ByteW],
        byte_starts:  s_axis_tuser,
        byte_ends:    s_axis_tlast
      };
    end
  end

  i2cmw_step u_step (
    .state_i    (st_q),
    .word_i     (in_q),
    .dev_addr_i (dev_addr_q),
    .delay_i    (delay_q),
    .state_o    (st_d),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateRst;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {
    {(OutTdataW - 6){1'b0}},
    out_q.engine_busy,
    out_q.transfer_nack,
    out_q.transfer_done,
    out_q.byte_taken,
    out_q.sda_drive,
    out_q.scl_drive
  };

endmodule

// ===== design/i2cmw_checker.sv =====
module i2cmw_checker import i2cmw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  logic out_fire;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_done_nack_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[OutDoneBit] && m_axis_tdata[OutNackBit]))
    else $error("done and nack in one word");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[OutDoneBit] || m_axis_tdata[OutNackBit])
      |-> !m_axis_tdata[OutBusyBit])
    else $error("finish pulse while busy");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OutBusyBit]
      |-> m_axis_tdata[OutSclBit] && m_axis_tdata[OutSdaBit])
    else $error("bus line pulled low while idle");

  // a finish word returns the engine to idle, so the next word cannot be a second finish
  a_single_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (m_axis_tdata[OutDoneBit] || m_axis_tdata[OutNackBit]) ##1 out_fire
      |-> !m_axis_tdata[OutDoneBit] && !m_axis_tdata[OutNackBit])
    else $error("back to back finish pulses");

endmodule

bind i2c_master_write_engine_top i2cmw_checker u_i2cmw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
